[rtl/core/iarf_pkg.sv]
// ----------------------------------------------------------------------------
// iarf_pkg
// Shared types and constants of the mean-as-reduced-fraction block.
// ----------------------------------------------------------------------------
package iarf_pkg;

	localparam int unsigned WHOLE_W = 16;
	localparam int unsigned NUM_W   = 7;
	localparam int unsigned DEN_W   = 8;

	typedef enum logic [2:0] {
		FU_IDLE,
		FU_ABS,
		FU_DIV,
		FU_GCD,
		FU_RED,
		FU_HOLD
	} fu_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fu_status_t;

	typedef struct packed {
		logic               negative;
		logic               is_zero;
		logic [WHOLE_W-1:0] whole_part;
		logic [NUM_W-1:0]   frac_numerator;
		logic [DEN_W-1:0]   frac_denominator;
		logic               overflow;
	} result_t;

endpackage

[rtl/core/iarf_sample_if.sv]
// ----------------------------------------------------------------------------
// iarf_sample_if
// Input channel: one signed value per word, with a last-of-set flag.
// ----------------------------------------------------------------------------
interface iarf_sample_if #(
	parameter int unsigned VALUE_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/core/iarf_result_if.sv]
// ----------------------------------------------------------------------------
// iarf_result_if
// Output channel: the mean of one set as a reduced mixed fraction.
// ----------------------------------------------------------------------------
interface iarf_result_if;
	logic                               valid;
	logic                               ready;
	logic                               negative;
	logic                               is_zero;
	logic [iarf_pkg::WHOLE_W-1:0]       whole_part;
	logic [iarf_pkg::NUM_W-1:0]         frac_numerator;
	logic [iarf_pkg::DEN_W-1:0]         frac_denominator;
	logic                               overflow;

	modport source (
		output valid, output negative, output is_zero, output whole_part,
		output frac_numerator, output frac_denominator, output overflow,
		input ready
	);
	modport sink (
		input valid, input negative, input is_zero, input whole_part,
		input frac_numerator, input frac_denominator, input overflow,
		output ready
	);
endinterface

[rtl/core/integer_average_reduced_fraction_top.sv]
// ----------------------------------------------------------------------------
// integer_average_reduced_fraction_top
// Mean of a set of signed values as a sign, whole part and reduced fraction.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one signed value per word; last marks the final value of a set.
//   result: one word per set, sent after its last sample word.
//   Values are summed and counted one word per cycle while ready is high.
//   Values past MAX_ITEMS in a set are dropped and flag overflow.
//   After the last word, ready drops while the fraction unit works: it
//   takes the sign and magnitude, runs the bit-serial divide of the sum
//   (SUM_W = VALUE_WIDTH + clog2(MAX_ITEMS+1) bits), a binary gcd and a
//   bit-serial reduction over CNT_W-bit operands, then holds the result
//   until it moves into the output register (CNT_W = clog2(MAX_ITEMS+1)).
//   A stalled result stays in the output register; the next set is taken
//   meanwhile, and its result waits in the fraction unit until the slot frees.
//   Reset clears the sum, count, overflow flag, result valid flag and unit state.
// ----------------------------------------------------------------------------
module integer_average_reduced_fraction_top #(
	parameter int unsigned MAX_ITEMS   = 128,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	iarf_sample_if.sink       sample,
	iarf_result_if.source     result
);

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned SUM_W = VALUE_WIDTH + CNT_W;

	logic signed [SUM_W-1:0] sum_q, sum_next;
	logic [CNT_W-1:0]        cnt_q, cnt_next;
	logic                    ovf_q, ovf_next;
	logic                    accept, start, take;

	iarf_pkg::fu_status_t    fu_status;
	iarf_pkg::result_t       fu_res, res_q;
	logic                    res_valid_q;

	assign sample.ready = !fu_status.busy;
	assign accept       = sample.valid && sample.ready;
	assign start        = accept && sample.last;
	assign take         = fu_status.done && (!res_valid_q || result.ready);

	always_comb begin
		sum_next = sum_q;
		cnt_next = cnt_q;
		ovf_next = ovf_q;
		if (cnt_q < CNT_W'(MAX_ITEMS)) begin
			sum_next = sum_q + {{CNT_W{sample.value[VALUE_WIDTH-1]}}, sample.value};
			cnt_next = cnt_q + 1'b1;
		end else begin
			ovf_next = 1'b1;
		end
	end

	iarf_frac_unit #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sum    (sum_next),
		.cnt    (cnt_next),
		.ovf    (ovf_next),
		.take   (take),
		.status (fu_status),
		.res    (fu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (sample.last) begin
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
				ovf_q <= ovf_next;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= fu_res;
	end

	assign result.valid            = res_valid_q;
	assign result.negative         = res_q.negative;
	assign result.is_zero          = res_q.is_zero;
	assign result.whole_part       = res_q.whole_part;
	assign result.frac_numerator   = res_q.frac_numerator;
	assign result.frac_denominator = res_q.frac_denominator;
	assign result.overflow         = res_q.overflow;

endmodule

[rtl/core/iarf_frac_unit.sv]
// ----------------------------------------------------------------------------
// iarf_frac_unit
// Bit-serial divide of |sum| by count, binary gcd of count and remainder,
// then bit-serial reduction of numerator and denominator by the gcd.
// ----------------------------------------------------------------------------
module iarf_frac_unit #(
	parameter int unsigned SUM_W = 24,
	parameter int unsigned CNT_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    sum,
	input  logic [CNT_W-1:0]           cnt,
	input  logic                       ovf,
	input  logic                       take,
	output iarf_pkg::fu_status_t       status,
	output iarf_pkg::result_t          res
);

	localparam int unsigned STEP_W = $clog2(SUM_W + 1);
	localparam int unsigned K_W    = $clog2(CNT_W + 1);

	iarf_pkg::fu_state_t state_q, state_d;

	logic                neg_q, zero_q, ovf_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    prem_q, cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    ga_q, gb_q, g_q;
	logic [K_W-1:0]      gk_q;
	logic [CNT_W-1:0]    den_q, num_q, ra_q, rb_q;

	// long division step
	logic [CNT_W:0]      div_trial, div_diff;
	logic                div_ge;
	logic [CNT_W-1:0]    prem_next;
	logic                div_last;

	// reduction steps
	logic [CNT_W:0]      ra_trial, rb_trial, ra_diff, rb_diff;
	logic                ra_ge, rb_ge;
	logic                red_last;

	logic                gcd_done;
	logic [CNT_W-1:0]    gcd_val;

	always_comb begin
		div_trial = {prem_q, quo_q[SUM_W-1]};
		div_diff  = div_trial - {1'b0, cnt_q};
		div_ge    = div_trial >= {1'b0, cnt_q};
		prem_next = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
		div_last  = step_q == STEP_W'(SUM_W - 1);

		ra_trial  = {ra_q, den_q[CNT_W-1]};
		rb_trial  = {rb_q, num_q[CNT_W-1]};
		ra_diff   = ra_trial - {1'b0, g_q};
		rb_diff   = rb_trial - {1'b0, g_q};
		ra_ge     = ra_trial >= {1'b0, g_q};
		rb_ge     = rb_trial >= {1'b0, g_q};
		red_last  = step_q == STEP_W'(CNT_W - 1);

		// one operand reaching zero ends the binary gcd
		gcd_done  = (ga_q == '0) || (gb_q == '0);
		gcd_val   = (ga_q == '0) ? CNT_W'(gb_q << gk_q) : CNT_W'(ga_q << gk_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iarf_pkg::FU_IDLE: if (start) state_d = iarf_pkg::FU_ABS;
			iarf_pkg::FU_ABS:  state_d = iarf_pkg::FU_DIV;
			iarf_pkg::FU_DIV:  if (div_last) state_d = iarf_pkg::FU_GCD;
			iarf_pkg::FU_GCD:  if (gcd_done) state_d = iarf_pkg::FU_RED;
			iarf_pkg::FU_RED:  if (red_last) state_d = iarf_pkg::FU_HOLD;
			iarf_pkg::FU_HOLD: if (take) state_d = iarf_pkg::FU_IDLE;
			default:           state_d = iarf_pkg::FU_IDLE;
		endcase
	end

	always_comb begin
		status.busy = state_q != iarf_pkg::FU_IDLE;
		status.done = state_q == iarf_pkg::FU_HOLD;
		res.negative         = neg_q;
		res.is_zero          = zero_q;
		res.whole_part       = iarf_pkg::WHOLE_W'(quo_q);
		res.frac_numerator   = iarf_pkg::NUM_W'(num_q);
		res.frac_denominator = iarf_pkg::DEN_W'(den_q);
		res.overflow         = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iarf_pkg::FU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			iarf_pkg::FU_IDLE: begin
				if (start) begin
					quo_q  <= sum;
					neg_q  <= sum[SUM_W-1];
					zero_q <= sum == '0;
					cnt_q  <= cnt;
					ovf_q  <= ovf;
				end
			end
			iarf_pkg::FU_ABS: begin
				if (neg_q) quo_q <= -quo_q;
				prem_q <= '0;
				step_q <= '0;
			end
			iarf_pkg::FU_DIV: begin
				quo_q  <= {quo_q[SUM_W-2:0], div_ge};
				prem_q <= prem_next;
				step_q <= step_q + 1'b1;
				if (div_last) begin
					// gcd(|sum|, count) equals gcd(count, remainder)
					ga_q <= cnt_q;
					gb_q <= prem_next;
					gk_q <= '0;
				end
			end
			iarf_pkg::FU_GCD: begin
				if (gcd_done) begin
					g_q    <= gcd_val;
					den_q  <= cnt_q;
					num_q  <= prem_q;
					ra_q   <= '0;
					rb_q   <= '0;
					step_q <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			iarf_pkg::FU_RED: begin
				den_q  <= {den_q[CNT_W-2:0], ra_ge};
				num_q  <= {num_q[CNT_W-2:0], rb_ge};
				ra_q   <= ra_ge ? ra_diff[CNT_W-1:0] : ra_trial[CNT_W-1:0];
				rb_q   <= rb_ge ? rb_diff[CNT_W-1:0] : rb_trial[CNT_W-1:0];
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
